// File: rtl/cfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_pkg
// shared types and constants of the coordinate frame parser
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int unsigned CfgAddrW = 4;

  localparam logic [CfgAddrW-1:0] CfgStartByte  = 4'd0;
  localparam logic [CfgAddrW-1:0] CfgTargetTag  = 4'd1;
  localparam logic [CfgAddrW-1:0] CfgStopByte   = 4'd2;
  localparam logic [CfgAddrW-1:0] CfgCoordLimit = 4'd3;

  localparam logic [7:0] RstStartByte  = 8'd64;
  localparam logic [7:0] RstTargetTag  = 8'd84;
  localparam logic [7:0] RstStopByte   = 8'd88;
  localparam logic [7:0] RstCoordLimit = 8'd95;

  // frame lengths in bytes
  localparam logic [2:0] CamLen = 3'd6;
  localparam logic [2:0] TgtLen = 3'd7;

  localparam logic KindCamera = 1'b0;
  localparam logic KindTarget = 1'b1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFraming  = 2'd1,
    StChecksum = 2'd2,
    StRange    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] target_tag;
    logic [7:0] stop_byte;
    logic [7:0] coord_limit;
  } cfg_t;

  typedef struct packed {
    logic       frame_kind;
    status_e    status;
    logic [7:0] x_raw;
    logic [7:0] y_raw;
  } res_t;

endpackage

// File: rtl/cfp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_cfg_regs
// configuration register file, written through its own valid/ready channel
// ----------------------------------------------------------------------------
module cfp_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [cfp_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [7:0]                   cfg_data_i,
  output      cfp_pkg::cfg_t                cfg_o
);

  cfp_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        cfp_pkg::CfgStartByte:  cfg_d.start_byte  = cfg_data_i;
        cfp_pkg::CfgTargetTag:  cfg_d.target_tag  = cfg_data_i;
        cfp_pkg::CfgStopByte:   cfg_d.stop_byte   = cfg_data_i;
        cfp_pkg::CfgCoordLimit: cfg_d.coord_limit = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte  <= cfp_pkg::RstStartByte;
      cfg_q.target_tag  <= cfp_pkg::RstTargetTag;
      cfg_q.stop_byte   <= cfp_pkg::RstStopByte;
      cfg_q.coord_limit <= cfp_pkg::RstCoordLimit;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: rtl/cfp_assembler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_assembler
// fill counters, frame stores and the check of a completed frame
// ----------------------------------------------------------------------------
module cfp_assembler (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    byte_i,
  input  wire cfp_pkg::cfg_t cfg_i,
  output      logic          res_valid_o,
  output      cfp_pkg::res_t res_o
);

  logic [2:0] cam_fill_q, cam_fill_d;
  logic [2:0] tgt_fill_q, tgt_fill_d;
  logic [7:0] cam_q [5];
  logic [7:0] cam_d [5];
  logic [7:0] tgt_q [7];
  logic [7:0] tgt_d [7];
  logic       cam_done, tgt_done;
  logic [2:0] cam_inc, tgt_inc;

  function automatic logic in_range(logic [7:0] v, logic [7:0] lim);
    logic [8:0] ext;
    logic [8:0] mag;
    ext = {v[7], v};
    mag = v[7] ? (9'd0 - ext) : ext;
    return mag <= {1'b0, lim};
  endfunction

  assign cam_inc = cam_fill_q + 3'd1;
  assign tgt_inc = tgt_fill_q + 3'd1;

  always_comb begin
    cam_fill_d = cam_fill_q;
    tgt_fill_d = tgt_fill_q;
    cam_d      = cam_q;
    tgt_d      = tgt_q;
    cam_done   = 1'b0;
    tgt_done   = 1'b0;
    if (step_i) begin
      if (byte_i == cfg_i.start_byte) begin
        cam_d[0]   = byte_i;
        tgt_d[0]   = byte_i;
        cam_fill_d = 3'd1;
        tgt_fill_d = 3'd1;
      end else if (cam_fill_q == 3'd0 && tgt_fill_q == 3'd0) begin
        // idle, byte dropped
      end else if ((cam_fill_q == 3'd1 || tgt_fill_q == 3'd1)
                   && byte_i == cfg_i.target_tag) begin
        cam_fill_d = 3'd0;
        if (tgt_fill_q < cfp_pkg::TgtLen) begin
          tgt_d[tgt_fill_q] = byte_i;
          tgt_fill_d        = tgt_inc;
        end
      end else if (tgt_fill_q > 3'd1) begin
        if (tgt_fill_q < cfp_pkg::TgtLen) begin
          tgt_d[tgt_fill_q] = byte_i;
        end
        if (tgt_fill_q == cfp_pkg::TgtLen || tgt_inc == cfp_pkg::TgtLen) begin
          tgt_done   = 1'b1;
          tgt_fill_d = 3'd0;
        end else begin
          tgt_fill_d = tgt_inc;
        end
      end else begin
        // last camera byte is used at once and never stored
        if (cam_fill_q < cfp_pkg::CamLen - 3'd1) begin
          cam_d[cam_fill_q] = byte_i;
        end
        if (cam_inc == cfp_pkg::CamLen) begin
          cam_done   = 1'b1;
          cam_fill_d = 3'd0;
        end else begin
          cam_fill_d = cam_inc;
        end
      end
    end
  end

  logic [10:0] cam_sum, tgt_sum;
  logic        cam_frm_ok, tgt_frm_ok;
  logic        cam_sum_ok, tgt_sum_ok;
  logic        cam_rng_ok, tgt_rng_ok;

  assign cam_sum = 11'(cam_d[0]) + 11'(cam_d[1]) + 11'(cam_d[2]) + 11'(cam_d[3]);
  assign tgt_sum = 11'(tgt_d[0]) + 11'(tgt_d[1]) + 11'(tgt_d[2]) + 11'(tgt_d[3])
                 + 11'(tgt_d[4]);

  assign cam_frm_ok = cam_d[0] == cfg_i.start_byte && cam_d[3] == cfg_i.stop_byte;
  assign tgt_frm_ok = tgt_d[0] == cfg_i.start_byte && tgt_d[1] == cfg_i.target_tag
                   && tgt_d[4] == cfg_i.stop_byte;
  assign cam_sum_ok = {5'd0, cam_sum} == {byte_i, cam_d[4]};
  assign tgt_sum_ok = {5'd0, tgt_sum} == {tgt_d[6], tgt_d[5]};
  assign cam_rng_ok = in_range(cam_d[1], cfg_i.coord_limit)
                   && in_range(cam_d[2], cfg_i.coord_limit);
  assign tgt_rng_ok = in_range(tgt_d[2], cfg_i.coord_limit)
                   && in_range(tgt_d[3], cfg_i.coord_limit);

  always_comb begin
    res_o = '0;
    if (tgt_done) begin
      res_o.frame_kind = cfp_pkg::KindTarget;
      res_o.x_raw      = tgt_d[2];
      res_o.y_raw      = tgt_d[3];
      if (!tgt_frm_ok)      res_o.status = cfp_pkg::StFraming;
      else if (!tgt_sum_ok) res_o.status = cfp_pkg::StChecksum;
      else if (!tgt_rng_ok) res_o.status = cfp_pkg::StRange;
      else                  res_o.status = cfp_pkg::StOk;
    end else begin
      res_o.frame_kind = cfp_pkg::KindCamera;
      res_o.x_raw      = cam_d[1];
      res_o.y_raw      = cam_d[2];
      if (!cam_frm_ok)      res_o.status = cfp_pkg::StFraming;
      else if (!cam_sum_ok) res_o.status = cfp_pkg::StChecksum;
      else if (!cam_rng_ok) res_o.status = cfp_pkg::StRange;
      else                  res_o.status = cfp_pkg::StOk;
    end
  end

  assign res_valid_o = cam_done || tgt_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_fill_q <= 3'd0;
      tgt_fill_q <= 3'd0;
      cam_q      <= '{default: 8'd0};
      tgt_q      <= '{default: 8'd0};
    end else begin
      cam_fill_q <= cam_fill_d;
      tgt_fill_q <= tgt_fill_d;
      cam_q      <= cam_d;
      tgt_q      <= tgt_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/coordinate_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coordinate_frame_parser
// assembles camera and target coordinate frames from a received byte stream
// ----------------------------------------------------------------------------
// slave stream: one received byte per beat in s_axis_tdata_i
// master stream: one beat per completed frame; tuser holds the frame kind,
//   tdata holds status, x and y
// config channel: cfg_addr_i selects start byte, target tag, stop byte or
//   coordinate limit; always ready, write only while the stream is idle
// a byte is registered on acceptance and processed once the result register
//   is free; the result of a frame's last byte passes the input register and
//   then the result register before it is on the master side
// throughput is one byte per cycle while the master side does not stall, set by
// the single processing stage between the input register and the result register
// if the master side stalls with a result held, the processing stage waits
//   and the input register fills, then tready drops; nothing is lost
// reset clears both fill counters and frame stores, empties both registers
//   and loads the default configuration
// ----------------------------------------------------------------------------
module coordinate_frame_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output      logic                         s_axis_tready_o,
  input  wire logic [7:0]                   s_axis_tdata_i,  // rx_byte
  output      logic                         m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output      logic [23:0]                  m_axis_tdata_o,  // status, x_raw, y_raw, pad
  output      logic                         m_axis_tuser_o,  // frame_kind
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [cfp_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [7:0]                   cfg_data_i
);

  cfp_pkg::cfg_t cfg;
  cfp_pkg::res_t res;
  logic          res_valid;

  logic          in_valid_q, in_valid_d;
  logic [7:0]    rx_q;
  logic          out_valid_q, out_valid_d;
  cfp_pkg::res_t out_q;
  logic          out_free, advance;

  cfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cfp_assembler u_asm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (rx_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      rx_q <= s_axis_tdata_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.frame_kind;
  assign m_axis_tdata_o  = {6'd0, out_q.y_raw, out_q.x_raw, out_q.status};

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while processing stage is blocked");

  a_result_from_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared without a processed beat");

  a_held_byte_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(rx_q))
    else $error("waiting beat lost or changed");

endmodule
`default_nettype wire

// File: dv/coordinate_frame_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coordinate_frame_parser_checker
// watches the byte, result and config channels of the frame parser, runs its
// own model of both frame assemblers on every accepted byte and compares each
// result beat against the oldest predicted frame report
// ----------------------------------------------------------------------------
module coordinate_frame_parser_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_i,
  input  logic [7:0]                   s_axis_tdata_i,  // rx_byte
  input  logic                         m_axis_tvalid_i,
  input  logic                         m_axis_tready_i,
  input  logic [23:0]                  m_axis_tdata_i,  // status, x_raw, y_raw, pad
  input  logic                         m_axis_tuser_i,  // frame_kind
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [cfp_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [7:0]                   cfg_data_i,
  output int                           mismatch_cnt_o,
  output int                           frames_due_o
);

  import cfp_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] cam_fill_q;
  logic [2:0] tgt_fill_q;
  logic [7:0] cam_frame_q [0:5];
  logic [7:0] tgt_frame_q [0:6];
  res_t       frame_reports_q [$];
  res_t       got;
  res_t       want;

  function automatic logic coord_ok(input logic [7:0] v);
    int val;
    val = $signed(v);
    return (val >= -int'(cfg_q.coord_limit)) && (val <= int'(cfg_q.coord_limit));
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    res_t        rep;
    logic [15:0] byte_total;
    if (b == cfg_q.start_byte) begin
      cam_frame_q[0] = b;
      tgt_frame_q[0] = b;
      cam_fill_q = 3'd1;
      tgt_fill_q = 3'd1;
    end else if (cam_fill_q == 3'd0 && tgt_fill_q == 3'd0) begin
      // idle, byte dropped
    end else if ((cam_fill_q == 3'd1 || tgt_fill_q == 3'd1) && b == cfg_q.target_tag) begin
      cam_fill_q = 3'd0;
      if (tgt_fill_q < TgtLen) begin
        tgt_frame_q[tgt_fill_q] = b;
        tgt_fill_q = tgt_fill_q + 3'd1;
      end
    end else if (tgt_fill_q > 3'd1) begin
      if (tgt_fill_q < TgtLen) begin
        tgt_frame_q[tgt_fill_q] = b;
        tgt_fill_q = tgt_fill_q + 3'd1;
      end
      if (tgt_fill_q == TgtLen) begin
        byte_total = 16'(tgt_frame_q[0]) + 16'(tgt_frame_q[1]) + 16'(tgt_frame_q[2])
                   + 16'(tgt_frame_q[3]) + 16'(tgt_frame_q[4]);
        rep.frame_kind = KindTarget;
        rep.x_raw = tgt_frame_q[2];
        rep.y_raw = tgt_frame_q[3];
        if (tgt_frame_q[0] != cfg_q.start_byte || tgt_frame_q[1] != cfg_q.target_tag ||
            tgt_frame_q[4] != cfg_q.stop_byte) begin
          rep.status = StFraming;
        end else if (byte_total != {tgt_frame_q[6], tgt_frame_q[5]}) begin
          rep.status = StChecksum;
        end else if (!coord_ok(tgt_frame_q[2]) || !coord_ok(tgt_frame_q[3])) begin
          rep.status = StRange;
        end else begin
          rep.status = StOk;
        end
        frame_reports_q.push_back(rep);
        tgt_fill_q = 3'd0;
      end
    end else begin
      if (cam_fill_q < CamLen) begin
        cam_frame_q[cam_fill_q] = b;
        cam_fill_q = cam_fill_q + 3'd1;
      end
      if (cam_fill_q == CamLen) begin
        byte_total = 16'(cam_frame_q[0]) + 16'(cam_frame_q[1]) + 16'(cam_frame_q[2])
                   + 16'(cam_frame_q[3]);
        rep.frame_kind = KindCamera;
        rep.x_raw = cam_frame_q[1];
        rep.y_raw = cam_frame_q[2];
        if (cam_frame_q[0] != cfg_q.start_byte || cam_frame_q[3] != cfg_q.stop_byte) begin
          rep.status = StFraming;
        end else if (byte_total != {cam_frame_q[5], cam_frame_q[4]}) begin
          rep.status = StChecksum;
        end else if (!coord_ok(cam_frame_q[1]) || !coord_ok(cam_frame_q[2])) begin
          rep.status = StRange;
        end else begin
          rep.status = StOk;
        end
        frame_reports_q.push_back(rep);
        cam_fill_q = 3'd0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q = {RstStartByte, RstTargetTag, RstStopByte, RstCoordLimit};
      cam_fill_q = 3'd0;
      tgt_fill_q = 3'd0;
      foreach (cam_frame_q[i]) cam_frame_q[i] = 8'd0;
      foreach (tgt_frame_q[i]) tgt_frame_q[i] = 8'd0;
      frame_reports_q.delete();
    end else begin
      // result beat first: a byte accepted now cannot complete a frame this cycle
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.frame_kind = m_axis_tuser_i;
        got.status = status_e'(m_axis_tdata_i[1:0]);
        got.x_raw = m_axis_tdata_i[9:2];
        got.y_raw = m_axis_tdata_i[17:10];
        if (frame_reports_q.size() == 0) begin
          if (mismatch_cnt_o < 10) begin
            $display("%0t: unexpected result beat kind %0d status %0d x %0d y %0d", $time,
                     got.frame_kind, got.status, $signed(got.x_raw), $signed(got.y_raw));
          end
          mismatch_cnt_o <= mismatch_cnt_o + 1;
        end else begin
          want = frame_reports_q.pop_front();
          if (got.frame_kind !== want.frame_kind || got.status !== want.status ||
              got.x_raw !== want.x_raw || got.y_raw !== want.y_raw) begin
            if (mismatch_cnt_o < 10) begin
              $display("%0t: frame report mismatch exp kind %0d status %0d x %0d y %0d",
                       $time, want.frame_kind, want.status, $signed(want.x_raw),
                       $signed(want.y_raw));
              $display("%0t:                       got kind %0d status %0d x %0d y %0d",
                       $time, got.frame_kind, got.status, $signed(got.x_raw),
                       $signed(got.y_raw));
            end
            mismatch_cnt_o <= mismatch_cnt_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          CfgStartByte:  cfg_q.start_byte = cfg_data_i;
          CfgTargetTag:  cfg_q.target_tag = cfg_data_i;
          CfgStopByte:   cfg_q.stop_byte = cfg_data_i;
          CfgCoordLimit: cfg_q.coord_limit = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        parse_byte(s_axis_tdata_i);
      end
    end
    frames_due_o <= frame_reports_q.size();
  end

endmodule

// File: dv/coordinate_frame_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coordinate_frame_parser_tb
// drives byte streams into the frame parser: a directed run over the corner
// cases of both frame kinds, then phases of random well-formed, faulty and
// truncated frames mixed with noise under several register settings, with
// random gaps and stalls on both streams
// ----------------------------------------------------------------------------
module coordinate_frame_parser_tb;

  import cfp_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseBytes = 165;

  typedef enum int {
    FaultNone,
    FaultStop,
    FaultSum,
    FaultCut
  } fault_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [23:0]         m_tdata;
  logic                m_tuser;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [7:0]          cfg_data;

  int         mismatches;
  int         frames_due;
  int         cycle_cnt = 0;
  int         bytes_sent = 0;
  logic       tx_idle_en;
  logic       rx_idle_en;
  logic [7:0] cur_start = RstStartByte;
  logic [7:0] cur_tag = RstTargetTag;
  logic [7:0] cur_stop = RstStopByte;
  logic [7:0] cur_limit = RstCoordLimit;

  always #1 clk_i = ~clk_i;

  coordinate_frame_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  coordinate_frame_parser_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data),
    .mismatch_cnt_o  (mismatches),
    .frames_due_o    (frames_due)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result sink with random stalls
  initial begin : sink
    int gap;
    m_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = rx_idle_en ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    do @(posedge clk_i); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic kind, input logic [7:0] x, input logic [7:0] y,
                            input fault_e fault);
    logic [7:0]  beat_data [0:6];
    logic [15:0] byte_total;
    int          n;
    int          cut;
    n = 0;
    beat_data[n] = cur_start;
    n++;
    if (kind == KindTarget) begin
      beat_data[n] = cur_tag;
      n++;
    end
    beat_data[n] = x;
    beat_data[n + 1] = y;
    beat_data[n + 2] = (fault == FaultStop) ? cur_stop ^ 8'($urandom_range(1, 255)) : cur_stop;
    n = n + 3;
    byte_total = 16'd0;
    for (int i = 0; i < n; i++) byte_total = byte_total + 16'(beat_data[i]);
    if (fault == FaultSum) byte_total = byte_total ^ 16'($urandom_range(1, 65535));
    beat_data[n] = byte_total[7:0];
    beat_data[n + 1] = byte_total[15:8];
    n = n + 2;
    cut = (fault == FaultCut) ? $urandom_range(1, n - 1) : n;
    for (int i = 0; i < cut; i++) send_byte(beat_data[i]);
  endtask

  // wait for every predicted frame plus the pipeline depth
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (frames_due != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic configure(input logic [7:0] start, input logic [7:0] tag,
                           input logic [7:0] stop, input logic [7:0] limit);
    settle();
    write_reg(CfgStartByte, start);
    write_reg(CfgTargetTag, tag);
    write_reg(CfgStopByte, stop);
    write_reg(CfgCoordLimit, limit);
    // unmapped index must leave everything alone
    write_reg(CfgAddrW'($urandom_range(4, 15)), 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    cur_start = start;
    cur_tag = tag;
    cur_stop = stop;
    cur_limit = limit;
  endtask

  function automatic logic [7:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return cur_limit;
      1: return -cur_limit;
      2: return cur_limit + 8'd1;
      3: return -(cur_limit + 8'd1);
      4: return 8'h80;
      5: return 8'h7f;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic fault_e pick_fault();
    case ($urandom_range(0, 9))
      6: return FaultStop;
      7: return FaultSum;
      8: return FaultCut;
      default: return FaultNone;
    endcase
  endfunction

  initial begin : stimulus
    logic [15:0] byte_total;
    int          phase_end;
    int          pick;
    rst_ni <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata <= 8'd0;
    cfg_valid <= 1'b0;
    cfg_addr <= '0;
    cfg_data <= 8'd0;
    tx_idle_en <= 1'b1;
    rx_idle_en <= 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bytes ignored while idle
    send_byte(8'h00);
    send_byte(8'hff);
    send_frame(KindCamera, 8'ha1, 8'd95, FaultNone);
    send_frame(KindTarget, 8'h80, 8'h7f, FaultNone);
    send_frame(KindCamera, 8'h01, 8'h02, FaultStop);
    send_frame(KindTarget, 8'h03, 8'h04, FaultSum);
    // start byte mid-frame restarts it
    send_byte(cur_start);
    send_byte(8'h11);
    send_frame(KindCamera, 8'h05, 8'hfb, FaultNone);
    // camera frame begun without a start byte
    for (int i = 1; i <= 6; i++) send_byte(8'(i));
    // tag byte resumes the target frame left open by the last start
    byte_total = 16'(cur_start) + 16'(cur_tag) + 16'h20 + 16'he0 + 16'(cur_stop);
    send_byte(cur_tag);
    send_byte(8'h20);
    send_byte(8'he0);
    send_byte(cur_stop);
    send_byte(byte_total[7:0]);
    send_byte(byte_total[15:8]);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: ;
        1: configure(8'h00, 8'hff, 8'h7f, 8'd0);
        2: configure(8'hff, 8'h00, 8'h80, 8'd128);
        default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 128)));
      endcase
      tx_idle_en <= ($urandom_range(0, 3) != 0);
      rx_idle_en <= ($urandom_range(0, 3) != 0);
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
          send_frame(1'($urandom_range(0, 1)), pick_coord(), pick_coord(), pick_fault());
        end else if (pick < 17) begin
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          case ($urandom_range(0, 2))
            0: send_byte(cur_start);
            1: send_byte(cur_tag);
            default: send_byte(cur_stop);
          endcase
        end
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && frames_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: coordinate_frame_parser.f
rtl/cfp_pkg.sv
rtl/cfp_cfg_regs.sv
rtl/cfp_assembler.sv
rtl/coordinate_frame_parser.sv
dv/coordinate_frame_parser_checker.sv
dv/coordinate_frame_parser_tb.sv
